### hw/rtl/assembly_text_tokenizer_macros.svh
// Assertion macros for the assembly text tokenizer.
// Included by the top level; expects clk and rst_n in scope.
`ifndef ASSEMBLY_TEXT_TOKENIZER_MACROS_SVH
`define ASSEMBLY_TEXT_TOKENIZER_MACROS_SVH

// Same-cycle implication, muted while in reset
`define ASMTOK_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted while in reset
`define ASMTOK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/asmtok_pkg.sv
// Shared types, character codes and helpers for the assembly text tokenizer.
// No dependencies.
package asmtok_pkg;

  localparam int unsigned OUTQ_DEPTH = 6;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_HASH  = 8'h23;

  localparam logic [4:0]  DEC_LEN_MAX = 5'd16;
  localparam logic [4:0]  HEX_LEN_MAX = 5'd16;
  localparam logic [4:0]  ID_LEN_MAX  = 5'd8;
  localparam logic [31:0] DEC_MAX     = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    KIND_COMMA   = 3'd0,
    KIND_COLON   = 3'd1,
    KIND_NEWLINE = 3'd2,
    KIND_DEC     = 3'd3,
    KIND_HEX     = 3'd4,
    KIND_IDENT   = 3'd5,
    KIND_EOF     = 3'd6,
    KIND_ERROR   = 3'd7
  } token_kind_t;

  typedef enum logic [4:0] {
    MODE_IDLE   = 5'b00001,
    MODE_DEC    = 5'b00010,
    MODE_HEX    = 5'b00100,
    MODE_IDENT  = 5'b01000,
    MODE_HALTED = 5'b10000
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    token_kind_t token_kind;
    logic [63:0] token_value;
    logic [4:0]  text_length;
    logic        too_long;
    logic [7:0]  bad_byte;
    logic        last_of_item;
  } out_item_t;

  // Up to two tokens produced by one text beat
  typedef struct packed {
    logic [1:0] n;
    out_item_t  first;
    out_item_t  second;
  } asmtok_push_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_hexch(input logic [7:0] b);
    return is_digit(b) || ((b >= 8'h61) && (b <= 8'h66));
  endfunction

  function automatic logic is_upper(input logic [7:0] b);
    return (b >= 8'h41) && (b <= 8'h5A);
  endfunction

  // '0'..'9' map through the low nibble; 'a'..'f' have low nibble 1..6
  function automatic logic [3:0] nibble(input logic [7:0] b);
    return is_digit(b) ? b[3:0] : (b[3:0] + 4'd9);
  endfunction

  function automatic out_item_t mk_tok(input token_kind_t kind, input logic [63:0] value,
                                       input logic [4:0] len, input logic tl,
                                       input logic [7:0] bad);
    out_item_t t;
    t.token_kind   = kind;
    t.token_value  = value;
    t.text_length  = len;
    t.too_long     = tl;
    t.bad_byte     = bad;
    t.last_of_item = 1'b0;
    return t;
  endfunction

endpackage

### hw/rtl/asmtok_scan.sv
// Scanner state and per-beat token decode for the assembly text tokenizer.
// Depends on asmtok_pkg.
module asmtok_scan import asmtok_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         item_v,
  input  in_item_t     item,
  output asmtok_push_t push
);

  scan_mode_t  mode_r, mode_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        ovf_r, ovf_nxt;

  logic [7:0]  b;
  logic        pend;
  token_kind_t flush_kind;
  out_item_t   flush_tok;
  out_item_t   tok;
  logic        tok_v;
  logic [35:0] dec_base;
  logic [35:0] dec_prod;

  assign b        = item.text_byte;
  assign pend     = (mode_r == MODE_DEC) || (mode_r == MODE_HEX) || (mode_r == MODE_IDENT);
  assign dec_base = {4'b0, acc_r[31:0]};
  // times ten as two shifts; a decimal accumulator never exceeds 32 bits
  assign dec_prod = (dec_base << 3) + (dec_base << 1) + {32'b0, b[3:0]};

  always_comb begin
    priority if (mode_r == MODE_DEC) begin
      flush_kind = KIND_DEC;
    end else if (mode_r == MODE_HEX) begin
      flush_kind = KIND_HEX;
    end else begin
      flush_kind = KIND_IDENT;
    end
    flush_tok = mk_tok(flush_kind, acc_r, cnt_r, ovf_r, 8'h00);
  end

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    push     = '0;
    tok      = '0;
    tok_v    = 1'b0;

    if (item_v) begin
      priority if (item.end_of_text) begin
        // flush whatever is pending, then eof, then back to reset state
        if (pend) begin
          push.n      = 2'd2;
          push.first  = flush_tok;
          push.second = mk_tok(KIND_EOF, 64'd0, 5'd0, 1'b0, 8'h00);
          push.second.last_of_item = 1'b1;
        end else begin
          push.n     = 2'd1;
          push.first = mk_tok(KIND_EOF, 64'd0, 5'd0, 1'b0, 8'h00);
          push.first.last_of_item = 1'b1;
        end
        mode_nxt = MODE_IDLE;
        acc_nxt  = '0;
        cnt_nxt  = '0;
        ovf_nxt  = 1'b0;
      end else if (mode_r == MODE_HALTED) begin
        // drop bytes until end of text
      end else if ((mode_r == MODE_DEC) && is_digit(b)) begin
        if (dec_prod[35:32] != 4'd0) begin
          acc_nxt = {32'b0, DEC_MAX};
          ovf_nxt = 1'b1;
        end else begin
          acc_nxt = {28'b0, dec_prod};
        end
        if (cnt_r < DEC_LEN_MAX) begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end else if ((mode_r == MODE_HEX) && is_hexch(b)) begin
        if (cnt_r < HEX_LEN_MAX) begin
          acc_nxt = {acc_r[59:0], nibble(b)};
          cnt_nxt = cnt_r + 5'd1;
        end else begin
          ovf_nxt = 1'b1;
        end
      end else if ((mode_r == MODE_IDENT) && (is_upper(b) || is_digit(b))) begin
        if (cnt_r < ID_LEN_MAX) begin
          acc_nxt = {acc_r[55:0], b};
          cnt_nxt = cnt_r + 5'd1;
        end else begin
          ovf_nxt = 1'b1;
        end
      end else begin
        // pending token ends here; start from a clean slate
        mode_nxt = MODE_IDLE;
        acc_nxt  = '0;
        cnt_nxt  = '0;
        ovf_nxt  = 1'b0;
        priority if (b == CH_SPACE) begin
          tok_v = 1'b0;
        end else if (b == CH_COMMA) begin
          tok_v = 1'b1;
          tok   = mk_tok(KIND_COMMA, 64'd0, 5'd0, 1'b0, 8'h00);
        end else if (b == CH_COLON) begin
          tok_v = 1'b1;
          tok   = mk_tok(KIND_COLON, 64'd0, 5'd0, 1'b0, 8'h00);
        end else if (b == CH_NL) begin
          tok_v = 1'b1;
          tok   = mk_tok(KIND_NEWLINE, 64'd0, 5'd0, 1'b0, 8'h00);
        end else if (b == CH_HASH) begin
          mode_nxt = MODE_DEC;
        end else if (is_hexch(b)) begin
          mode_nxt = MODE_HEX;
          acc_nxt  = {60'b0, nibble(b)};
          cnt_nxt  = 5'd1;
        end else if (is_upper(b)) begin
          mode_nxt = MODE_IDENT;
          acc_nxt  = {56'b0, b};
          cnt_nxt  = 5'd1;
        end else begin
          tok_v    = 1'b1;
          tok      = mk_tok(KIND_ERROR, 64'd0, 5'd0, 1'b0, b);
          mode_nxt = MODE_HALTED;
        end
        tok.last_of_item = 1'b1;
        priority if (pend && tok_v) begin
          push.n      = 2'd2;
          push.first  = flush_tok;
          push.second = tok;
        end else if (pend) begin
          push.n     = 2'd1;
          push.first = flush_tok;
          push.first.last_of_item = 1'b1;
        end else if (tok_v) begin
          push.n     = 2'd1;
          push.first = tok;
        end else begin
          push.n = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      acc_r  <= '0;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

### hw/rtl/asmtok_outq.sv
// Result queue for the assembly text tokenizer: takes up to two tokens per
// cycle and hands them out one beat at a time. Depends on asmtok_pkg.
module asmtok_outq import asmtok_pkg::*; #(
  parameter int unsigned QDEPTH = OUTQ_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  asmtok_push_t                   push,
  output logic                           out_valid,
  input  logic                           out_stall,
  output out_item_t                      out_data,
  output logic [$clog2(QDEPTH+1)-1:0]    q_count
);

  localparam int unsigned PW = $clog2(QDEPTH);
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  out_item_t         mem_r [QDEPTH];
  logic [PW-1:0]     wr_r, wr_nxt;
  logic [PW-1:0]     rd_r, rd_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [PW-1:0]     wr_plus1;
  logic              pop;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(QDEPTH - 1)) ? '0 : (p + 1'b1);
  endfunction

  assign wr_plus1  = wrap_inc(wr_r);
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_r];
  assign q_count   = cnt_r;
  assign pop       = out_valid && !out_stall;

  always_comb begin
    unique case (push.n)
      2'd1:    wr_nxt = wr_plus1;
      2'd2:    wr_nxt = wrap_inc(wr_plus1);
      default: wr_nxt = wr_r;
    endcase
    rd_nxt  = pop ? wrap_inc(rd_r) : rd_r;
    cnt_nxt = cnt_r + CW'(push.n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_r] <= push.first;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_plus1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### hw/rtl/assembly_text_tokenizer.sv
// Assembly text tokenizer, top level. One text beat a cycle while in_stall is low;
// a taken beat is registered in the staging register, decoded by the scanner, and
// its tokens are written to the result queue, which offers them on out_ in order.
// Rate is one text beat per cycle while the result queue (QDEPTH entries) drains;
// beats that make two tokens need two output beats. Synchronous active-low reset
// clears the scanner mode, token counters and the queue pointers; no clearing pass.
`include "assembly_text_tokenizer_macros.svh"

module assembly_text_tokenizer import asmtok_pkg::*; #(
  parameter int unsigned QDEPTH = OUTQ_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int unsigned CW = $clog2(QDEPTH + 1);

  logic          pipe_v_r, pipe_v_nxt;
  in_item_t      pipe_d_r;
  asmtok_push_t  push;
  logic [CW-1:0] q_count;
  logic          in_acc;

  // hold input while the queue could not absorb two tokens from each beat in flight
  assign in_stall   = ({1'b0, q_count} + {{(CW - 1){1'b0}}, pipe_v_r, 1'b0}) >
                      (CW + 1)'(QDEPTH - 2);
  assign in_acc     = in_valid && !in_stall;
  assign pipe_v_nxt = in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_v_r <= 1'b0;
    end else begin
      pipe_v_r <= pipe_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pipe_d_r <= in_data;
    end
  end

  asmtok_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .item_v (pipe_v_r),
    .item   (pipe_d_r),
    .push   (push)
  );

  asmtok_outq #(
    .QDEPTH (QDEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .q_count   (q_count)
  );

  `ASMTOK_ASSERT_HOLDS(a_last_marks_final, push.n != 2'd0, (push.n == 2'd1) ? push.first.last_of_item : (push.second.last_of_item && !push.first.last_of_item), "last_of_item not on final token of beat")
  `ASMTOK_ASSERT_HOLDS(a_queue_room, pipe_v_r, ({1'b0, q_count} + (CW + 1)'(push.n)) <= (CW + 1)'(QDEPTH), "result queue overrun")
  `ASMTOK_ASSERT_NEXT(a_accept_loads_pipe, in_acc, pipe_v_r, "accepted beat not staged")
  `ASMTOK_ASSERT_NEXT(a_push_shows_out, push.n != 2'd0, out_valid, "pushed token not offered")

endmodule

### tb/testbench.sv
// Self-checking testbench for assembly_text_tokenizer: directed token cases, then random
// source text with bursty input and a stalling receiver. Tokens are predicted per beat.
// Depends on asmtok_pkg and the tokenizer RTL.
module testbench;
  import asmtok_pkg::*;

  localparam int          TARGET_BEATS = 1850;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          MAX_REPORTS  = 10;
  localparam logic [7:0]  CH_0  = 8'h30;
  localparam logic [7:0]  CH_9  = 8'h39;
  localparam logic [7:0]  CH_LA = 8'h61;
  localparam logic [7:0]  CH_LF = 8'h66;
  localparam logic [7:0]  CH_UA = 8'h41;
  localparam logic [7:0]  CH_UZ = 8'h5A;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // scanner copy kept by the predictor
  scan_mode_t  scan = MODE_IDLE;
  logic [63:0] scan_acc = '0;
  logic [4:0]  scan_cnt = '0;
  logic        scan_ovf = 1'b0;

  out_item_t pending_tokens[$];
  int        mismatches = 0;
  int        sent_beats = 0;
  int        cycles = 0;
  int        burst_left = 0;

  assembly_text_tokenizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit dec_char(input logic [7:0] b);
    return b >= CH_0 && b <= CH_9;
  endfunction

  function automatic bit hex_char(input logic [7:0] b);
    return dec_char(b) || (b >= CH_LA && b <= CH_LF);
  endfunction

  function automatic bit letter_char(input logic [7:0] b);
    return b >= CH_UA && b <= CH_UZ;
  endfunction

  function automatic out_item_t make_token(input token_kind_t kind, input logic [63:0] value,
                                           input logic [4:0] len, input logic tl,
                                           input logic [7:0] bad);
    out_item_t t;
    t = '0;
    t.token_kind  = kind;
    t.token_value = value;
    t.text_length = len;
    t.too_long    = tl;
    t.bad_byte    = bad;
    return t;
  endfunction

  function automatic void clear_scan();
    scan     = MODE_IDLE;
    scan_acc = '0;
    scan_cnt = '0;
    scan_ovf = 1'b0;
  endfunction

  function automatic void append_hex(input logic [7:0] b);
    logic [3:0] nib;
    nib = dec_char(b) ? 4'(b - CH_0) : 4'(b - CH_LA + 8'd10);
    if (scan_cnt < HEX_LEN_MAX) begin
      scan_acc = {scan_acc[59:0], nib};
      scan_cnt = scan_cnt + 5'd1;
    end else begin
      scan_ovf = 1'b1;
    end
  endfunction

  function automatic void append_letter(input logic [7:0] b);
    if (scan_cnt < ID_LEN_MAX) begin
      scan_acc = {scan_acc[55:0], b};
      scan_cnt = scan_cnt + 5'd1;
    end else begin
      scan_ovf = 1'b1;
    end
  endfunction

  function automatic void append_decimal(input logic [7:0] b);
    logic [63:0] next_val;
    next_val = scan_acc * 64'd10 + {56'h0, b - CH_0};
    if (scan_acc > 64'(DEC_MAX) || next_val > 64'(DEC_MAX)) begin
      next_val = 64'(DEC_MAX);
      scan_ovf = 1'b1;
    end
    scan_acc = next_val;
    if (scan_cnt < DEC_LEN_MAX) scan_cnt = scan_cnt + 5'd1;
  endfunction

  // Hand back the token under construction, if any, and return to idle
  function automatic bit take_pending(output out_item_t t);
    token_kind_t kind;
    t = '0;
    case (scan)
      MODE_DEC:   kind = KIND_DEC;
      MODE_HEX:   kind = KIND_HEX;
      MODE_IDENT: kind = KIND_IDENT;
      default:    return 1'b0;
    endcase
    t = make_token(kind, scan_acc, scan_cnt, scan_ovf, 8'h00);
    clear_scan();
    return 1'b1;
  endfunction

  // Work out the tokens one accepted beat gives and queue them
  function automatic void lex_beat(input logic [7:0] b, input logic eot);
    out_item_t toks[2];
    out_item_t t;
    int        n;
    n = 0;
    if (eot) begin
      if (take_pending(t)) begin
        toks[n] = t;
        n++;
      end
      toks[n] = make_token(KIND_EOF, '0, '0, 1'b0, 8'h00);
      n++;
      clear_scan();
    end else if (scan == MODE_HALTED) begin
      return;
    end else if (scan == MODE_DEC && dec_char(b)) begin
      append_decimal(b);
    end else if (scan == MODE_HEX && hex_char(b)) begin
      append_hex(b);
    end else if (scan == MODE_IDENT && (letter_char(b) || dec_char(b))) begin
      append_letter(b);
    end else begin
      if (take_pending(t)) begin
        toks[n] = t;
        n++;
      end
      clear_scan();
      case (b)
        CH_SPACE: ;
        CH_COMMA: begin
          toks[n] = make_token(KIND_COMMA, '0, '0, 1'b0, 8'h00);
          n++;
        end
        CH_COLON: begin
          toks[n] = make_token(KIND_COLON, '0, '0, 1'b0, 8'h00);
          n++;
        end
        CH_NL: begin
          toks[n] = make_token(KIND_NEWLINE, '0, '0, 1'b0, 8'h00);
          n++;
        end
        CH_HASH: scan = MODE_DEC;
        default: begin
          if (hex_char(b)) begin
            scan = MODE_HEX;
            append_hex(b);
          end else if (letter_char(b)) begin
            scan = MODE_IDENT;
            append_letter(b);
          end else begin
            toks[n] = make_token(KIND_ERROR, '0, '0, 1'b0, b);
            n++;
            scan = MODE_HALTED;
          end
        end
      endcase
    end
    if (n > 0) toks[n-1].last_of_item = 1'b1;
    for (int i = 0; i < n; i++) pending_tokens = {pending_tokens, toks[i]};
  endfunction

  // Predict on every accepted text beat, then check every accepted token
  always @(posedge clk) begin
    out_item_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else if (rst_n) begin
      if (in_valid && !in_stall) begin
        sent_beats++;
        lex_beat(in_data.text_byte, in_data.end_of_text);
      end
      if (out_valid && !out_stall) begin
        if (pending_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected token: kind %0d value %h", out_data.token_kind,
                     out_data.token_value);
        end else begin
          want = pending_tokens.pop_front();
          if (out_data.token_kind !== want.token_kind ||
              out_data.token_value !== want.token_value ||
              out_data.text_length !== want.text_length ||
              out_data.too_long !== want.too_long ||
              out_data.bad_byte !== want.bad_byte ||
              out_data.last_of_item !== want.last_of_item) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("token mismatch at cycle %0d", cycles);
              $display("  expected kind %0d value %h len %0d long %b bad %h last %b",
                       want.token_kind, want.token_value, want.text_length,
                       want.too_long, want.bad_byte, want.last_of_item);
              $display("  actual   kind %0d value %h len %0d long %b bad %h last %b",
                       out_data.token_kind, out_data.token_value, out_data.text_length,
                       out_data.too_long, out_data.bad_byte, out_data.last_of_item);
            end
          end
        end
      end
    end
  end

  // Receiver: phases of no stall, scattered stalls and long stall runs
  int stall_style = 0;
  int phase_left = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (phase_left == 0) begin
      stall_style = $urandom_range(0, 2);
      phase_left  = $urandom_range(50, 300);
    end else begin
      phase_left--;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: begin
        if (hold_left > 0) begin
          hold_left--;
          out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
          hold_left = $urandom_range(1, 10);
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    endcase
  end

  // Offer one beat and hold it until taken; bursts are broken by idle gaps
  task automatic send_beat(input logic [7:0] b, input logic eot);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid              <= 1'b1;
    in_data.text_byte     <= b;
    in_data.end_of_text   <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  task automatic send_eot();
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_punctuation();
    send_text(" ,:\n");
    send_eot();
    send_eot();
  endtask

  // Empty immediate, then decimal, hex and identifier ending one another
  task automatic test_token_handover();
    send_text("#,#0fFF");
    send_eot();
    send_text("c");
    send_eot();
  endtask

  // Identifier flushed by a bad byte, halted text ignored, then end of text
  task automatic test_error_halt();
    send_text("A");
    send_beat(8'hFF, 1'b0);
    send_text("x#1");
    send_eot();
    send_beat(8'h00, 1'b0);
    send_eot();
  endtask

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    return (v < 10) ? CH_0 + 8'(v) : CH_LA + 8'(v - 10);
  endfunction

  function automatic logic [7:0] rand_ident_char();
    int v;
    v = $urandom_range(0, 35);
    return (v < 26) ? CH_UA + 8'(v) : CH_0 + 8'(v - 26);
  endfunction

  task automatic send_random_token();
    int pick;
    int len;
    bit nines;
    logic [7:0] seps[4];
    seps = '{CH_SPACE, CH_COMMA, CH_COLON, CH_NL};
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
      send_beat(CH_UA + 8'($urandom_range(0, 25)), 1'b0);
      for (int i = 1; i < len; i++) send_beat(rand_ident_char(), 1'b0);
    end else if (pick < 55) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) send_beat(rand_hex_char(), 1'b0);
    end else if (pick < 75) begin
      nines = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 10);
      send_beat(CH_HASH, 1'b0);
      for (int i = 0; i < len; i++)
        send_beat(nines ? CH_9 : CH_0 + 8'($urandom_range(0, 9)), 1'b0);
    end else if (pick < 92) begin
      send_beat(seps[$urandom_range(0, 3)], 1'b0);
    end else if (pick < 96) begin
      send_beat(8'($urandom_range(0, 255)), 1'b0);
      // close the text after noise half the time, the block may have halted
      if ($urandom_range(0, 1) == 0) send_eot();
    end else begin
      send_eot();
    end
    if ($urandom_range(0, 1) == 0) send_beat(seps[$urandom_range(0, 3)], 1'b0);
  endtask

  task automatic test_random_text();
    int start;
    start = sent_beats;
    while (sent_beats - start < TARGET_BEATS) send_random_token();
    send_eot();
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_punctuation();
    test_token_handover();
    test_error_halt();
    test_random_text();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### assembly_text_tokenizer.f
+incdir+hw/rtl
hw/rtl/asmtok_pkg.sv
hw/rtl/asmtok_scan.sv
hw/rtl/asmtok_outq.sv
hw/rtl/assembly_text_tokenizer.sv
tb/testbench.sv
